// ----- rtl/assert_macros.svh -----
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising clock edge outside reset.
`define CHECK_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Checks that a condition at one edge implies another at the next edge.
`define CHECK_NEXT(label, cond, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (expr)) \
		else $error(msg);

`endif

// ----- rtl/bprs_pkg.sv -----
package bprs_pkg;

	localparam int RATE_WIDTH_DEF = 32;
	localparam int FRAC_BITS_DEF = 16;
	localparam int AMT_W = 16;
	localparam int EXP_W = 6;
	localparam int TOL_W = 16;
	localparam logic [TOL_W-1:0] TOL_RESET = 16'd655;
	localparam int CHUNK_W = 16;

	localparam int PC_W = 4;
	localparam logic [PC_W-1:0] LAST_PC = 4'd10;

	typedef logic [3:0] op_t;
	localparam op_t OP_NONE = 4'd0;
	localparam op_t OP_LOAD = 4'd1;
	localparam op_t OP_MID = 4'd2;
	localparam op_t OP_MSP = 4'd3;
	localparam op_t OP_MSA = 4'd4;
	localparam op_t OP_MACC = 4'd5;
	localparam op_t OP_PWR = 4'd6;
	localparam op_t OP_UPD = 4'd7;
	localparam op_t OP_EMIT = 4'd8;

	typedef logic [2:0] cond_t;
	localparam cond_t C_NEVER = 3'd0;
	localparam cond_t C_ALWAYS = 3'd1;
	localparam cond_t C_NO_IN = 3'd2;
	localparam cond_t C_NOSOLVE = 3'd3;
	localparam cond_t C_CNT0 = 3'd4;
	localparam cond_t C_MORE = 3'd5;
	localparam cond_t C_OUT_FULL = 3'd6;

	typedef struct packed {
		op_t op;
		cond_t cond;
		logic [PC_W-1:0] target;
	} ctl_t;

	typedef struct packed {
		logic in_valid;
		logic no_solve;
		logic cnt_zero;
		logic chunk_more;
		logic out_full;
	} stat_t;

endpackage

// ----- rtl/bisection_power_root_solver.sv -----
// Channel   | Direction | Contents
// s_axis    | in        | tdata: amount, payment, exponent, high_guess, low_guess
// m_axis    | out       | tdata: rate; tuser: stepped
// cfg       | in        | data: tolerance
//
// Each bisection pass raises the midpoint to the exponent n and multiplies it by the amount,
// all on the single shared multiplier, which takes 16 bits of one operand a cycle, so that
// one operand is taken in C chunks, where C = RATE_WIDTH / 16 rounded up.
// Reset clears the step counter, the output valid flag and sets tolerance to 655.
// The next request is taken once the result has moved to the output register.
// A stalled output holds the sequencer in its emit step.
module bisection_power_root_solver
	import bprs_pkg::*;
#(
	parameter int RATE_WIDTH = RATE_WIDTH_DEF,
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic s_axis_tvalid,
	output logic s_axis_tready,
	// amount, payment, exponent, high_guess, low_guess, zero fill
	input logic [((2 * AMT_W + EXP_W + 2 * RATE_WIDTH + 7) / 8) * 8 - 1:0] s_axis_tdata,
	output logic m_axis_tvalid,
	input logic m_axis_tready,
	// rate, zero fill
	output logic [((RATE_WIDTH + 7) / 8) * 8 - 1:0] m_axis_tdata,
	// stepped
	output logic [0:0] m_axis_tuser,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [TOL_W-1:0] cfg_data
);

	`include "assert_macros.svh"

	localparam int OUT_W = ((RATE_WIDTH + 7) / 8) * 8;
	localparam int PAY_LO = AMT_W;
	localparam int EXP_LO = 2 * AMT_W;
	localparam int HI_LO = EXP_LO + EXP_W;
	localparam int LO_LO = HI_LO + RATE_WIDTH;

	ctl_t ctl;
	stat_t stat;
	logic signed [RATE_WIDTH-1:0] rate;
	logic stepped;

	assign s_axis_tready = (ctl.op == OP_LOAD);
	assign cfg_ready = 1'b1;
	assign m_axis_tdata = OUT_W'($unsigned(rate));
	assign m_axis_tuser = stepped;

	bprs_seq u_seq (
		.clk(clk),
		.arst_n(arst_n),
		.stat(stat),
		.ctl(ctl)
	);

	bprs_dp #(
		.RATE_WIDTH(RATE_WIDTH),
		.FRAC_BITS(FRAC_BITS)
	) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.ctl(ctl),
		.stat(stat),
		.in_valid(s_axis_tvalid),
		.amount(s_axis_tdata[AMT_W-1:0]),
		.payment(s_axis_tdata[PAY_LO +: AMT_W]),
		.exponent(s_axis_tdata[EXP_LO +: EXP_W]),
		.high_guess(s_axis_tdata[HI_LO +: RATE_WIDTH]),
		.low_guess(s_axis_tdata[LO_LO +: RATE_WIDTH]),
		.cfg_valid(cfg_valid),
		.cfg_data(cfg_data),
		.out_valid(m_axis_tvalid),
		.out_ready(m_axis_tready),
		.out_rate(rate),
		.out_stepped(stepped)
	);

	`CHECK_NEXT(a_one_at_a_time, s_axis_tvalid && s_axis_tready, !s_axis_tready, "request taken while busy")
	`CHECK_CLK(a_zero_rate, !(m_axis_tvalid && !stepped) || (rate == '0), "unstepped result not zero")
	`CHECK_NEXT(a_out_drain, m_axis_tvalid && m_axis_tready && (ctl.op != OP_EMIT), !m_axis_tvalid, "result repeated")

endmodule

// ----- rtl/bprs_seq.sv -----
module bprs_seq
	import bprs_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input stat_t stat,
	output ctl_t ctl
);

	logic [PC_W-1:0] pc_q;
	logic take;

	// Microprogram: load, bracket check, midpoint, power loop, amount product, update, emit.
	always_comb begin
		case (pc_q)
			4'd0: ctl = '{OP_LOAD, C_NO_IN, 4'd0};
			4'd1: ctl = '{OP_NONE, C_NOSOLVE, 4'd10};
			4'd2: ctl = '{OP_MID, C_NEVER, 4'd0};
			4'd3: ctl = '{OP_NONE, C_CNT0, 4'd7};
			4'd4: ctl = '{OP_MSP, C_NEVER, 4'd0};
			4'd5: ctl = '{OP_MACC, C_MORE, 4'd5};
			4'd6: ctl = '{OP_PWR, C_ALWAYS, 4'd3};
			4'd7: ctl = '{OP_MSA, C_NEVER, 4'd0};
			4'd8: ctl = '{OP_MACC, C_MORE, 4'd8};
			4'd9: ctl = '{OP_UPD, C_ALWAYS, 4'd1};
			4'd10: ctl = '{OP_EMIT, C_OUT_FULL, 4'd10};
			default: ctl = '{OP_NONE, C_ALWAYS, 4'd0};
		endcase
	end

	always_comb begin
		case (ctl.cond)
			C_NEVER: take = 1'b0;
			C_ALWAYS: take = 1'b1;
			C_NO_IN: take = !stat.in_valid;
			C_NOSOLVE: take = stat.no_solve;
			C_CNT0: take = stat.cnt_zero;
			C_MORE: take = stat.chunk_more;
			C_OUT_FULL: take = stat.out_full;
			default: take = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= '0;
		end else if (take) begin
			pc_q <= ctl.target;
		end else if (pc_q == LAST_PC) begin
			pc_q <= '0;
		end else begin
			pc_q <= pc_q + 1'b1;
		end
	end

endmodule

// ----- rtl/bprs_dp.sv -----
module bprs_dp
	import bprs_pkg::*;
#(
	parameter int RATE_WIDTH = RATE_WIDTH_DEF,
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input logic clk,
	input logic arst_n,
	input ctl_t ctl,
	output stat_t stat,
	input logic in_valid,
	input logic signed [AMT_W-1:0] amount,
	input logic signed [AMT_W-1:0] payment,
	input logic [EXP_W-1:0] exponent,
	input logic signed [RATE_WIDTH-1:0] high_guess,
	input logic signed [RATE_WIDTH-1:0] low_guess,
	input logic cfg_valid,
	input logic [TOL_W-1:0] cfg_data,
	output logic out_valid,
	input logic out_ready,
	output logic signed [RATE_WIDTH-1:0] out_rate,
	output logic out_stepped
);

	localparam int W = RATE_WIDTH;
	localparam int CHUNKS = (W + CHUNK_W - 1) / CHUNK_W;
	localparam int CK_W = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;
	localparam int MY_W = CHUNKS * CHUNK_W;
	localparam int ACC_W = W + MY_W;
	localparam int CW = ((W > AMT_W + FRAC_BITS) ? W : AMT_W + FRAC_BITS) + 1;
	localparam logic [ACC_W-1:0] MAXMAG = (ACC_W'(1) << (W - 1)) - ACC_W'(1);
	localparam logic [ACC_W-1:0] MINMAG = ACC_W'(1) << (W - 1);
	localparam logic [W-1:0] ONE = (FRAC_BITS <= W - 2) ? (W'(1) << FRAC_BITS) : MAXMAG[W-1:0];

	function automatic logic [W-1:0] sat(input logic [ACC_W-1:0] mag, input logic neg);
		logic [W-1:0] r;
		if (neg) begin
			if (mag > MINMAG) begin
				r = MINMAG[W-1:0];
			end else begin
				r = W'(0) - mag[W-1:0];
			end
		end else if (mag > MAXMAG) begin
			r = MAXMAG[W-1:0];
		end else begin
			r = mag[W-1:0];
		end
		return r;
	endfunction

	logic [TOL_W-1:0] tol_q;
	logic signed [AMT_W-1:0] a_q, pay_q;
	logic [EXP_W-1:0] n_q, cnt_q;
	logic signed [W-1:0] hi_q, lo_q, m_q, p_q, rate_q;
	logic stepped_q;
	logic [W-1:0] mx_q;
	logic [MY_W-1:0] my_q;
	logic neg_q;
	logic [ACC_W-1:0] acc_q;
	logic [CK_W-1:0] chunk_q;
	logic out_valid_q, out_stepped_q;
	logic signed [W-1:0] out_rate_q;

	logic [TOL_W-1:0] tol_eff;
	logic signed [W:0] diff, sum;
	logic signed [W-1:0] mid;
	logic [W-1:0] m_mag, p_mag;
	logic [AMT_W-1:0] a_mag;
	logic [W+CHUNK_W-1:0] part;
	logic [ACC_W-1:0] acc_next, acc_shr;
	logic signed [W-1:0] prod;
	logic signed [CW-1:0] prod_x, target_x;
	logic emit;

	assign tol_eff = (tol_q == '0) ? TOL_W'(1) : tol_q;
	assign diff = {hi_q[W-1], hi_q} - {lo_q[W-1], lo_q};
	assign sum = {hi_q[W-1], hi_q} + {lo_q[W-1], lo_q};
	assign mid = sum[W:1];
	assign m_mag = m_q[W-1] ? W'(0) - m_q : m_q;
	assign p_mag = p_q[W-1] ? W'(0) - p_q : p_q;
	assign a_mag = a_q[AMT_W-1] ? AMT_W'(0) - a_q : a_q;
	assign part = mx_q * my_q[MY_W-1 -: CHUNK_W];
	assign acc_next = (acc_q << CHUNK_W) + ACC_W'(part);
	assign acc_shr = acc_q >> FRAC_BITS;
	assign prod = sat(acc_q, neg_q && (acc_q != '0));
	assign prod_x = {{(CW - W){prod[W-1]}}, prod};
	assign target_x = {{(CW - AMT_W - FRAC_BITS){pay_q[AMT_W-1]}}, pay_q, FRAC_BITS'(0)};
	assign emit = (ctl.op == OP_EMIT) && (!out_valid_q || out_ready);

	assign stat.in_valid = in_valid;
	assign stat.no_solve = (a_q == '0) || !(diff > $signed({{(W + 1 - TOL_W){1'b0}}, tol_eff}));
	assign stat.cnt_zero = (cnt_q == '0);
	assign stat.chunk_more = (chunk_q != CK_W'(CHUNKS - 1));
	assign stat.out_full = out_valid_q && !out_ready;

	assign out_valid = out_valid_q;
	assign out_rate = out_rate_q;
	assign out_stepped = out_stepped_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q <= TOL_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				tol_q <= cfg_data;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (ctl.op)
			OP_LOAD: begin
				if (in_valid) begin
					a_q <= amount;
					pay_q <= payment;
					n_q <= exponent;
					hi_q <= high_guess;
					lo_q <= low_guess;
					rate_q <= '0;
					stepped_q <= 1'b0;
				end
			end
			OP_MID: begin
				m_q <= mid;
				rate_q <= mid;
				stepped_q <= 1'b1;
				p_q <= ONE;
				cnt_q <= n_q;
			end
			OP_MSP: begin
				mx_q <= p_mag;
				my_q <= MY_W'(m_mag);
				neg_q <= m_q[W-1] ^ p_q[W-1];
				acc_q <= '0;
				chunk_q <= '0;
			end
			OP_MSA: begin
				mx_q <= p_mag;
				my_q <= MY_W'(a_mag);
				neg_q <= a_q[AMT_W-1] ^ p_q[W-1];
				acc_q <= '0;
				chunk_q <= '0;
			end
			OP_MACC: begin
				acc_q <= acc_next;
				my_q <= my_q << CHUNK_W;
				chunk_q <= chunk_q + 1'b1;
			end
			OP_PWR: begin
				p_q <= sat(acc_shr, neg_q && (acc_shr != '0));
				cnt_q <= cnt_q - 1'b1;
			end
			OP_UPD: begin
				if (prod_x < target_x) begin
					lo_q <= m_q;
				end else begin
					hi_q <= m_q;
				end
			end
			OP_EMIT: begin
				if (emit) begin
					out_rate_q <= rate_q;
					out_stepped_q <= stepped_q;
				end
			end
			default: begin
			end
		endcase
	end

endmodule
